/* rtl/core/bmrsf_pkg.sv */
`timescale 1ns / 1ps

package bmrsf_pkg;

   localparam int MAP_BITS   = 4096;
   localparam int WORD_BITS  = 32;
   localparam int WORD_COUNT = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int POS_W      = $clog2(MAP_BITS);
   localparam int WORD_W     = $clog2(WORD_BITS);
   localparam int IDX_W      = $clog2(WORD_COUNT);
   localparam int CNT_W      = 13;

   localparam logic [CNT_W-1:0] BITS_IN_USE_RESET = CNT_W'(4096);
   localparam logic [CNT_W-1:0] MAP_LIMIT         = CNT_W'(MAP_BITS);

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_FIND  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } seq_state_type;

   typedef struct packed {
      logic                 rd_en;
      logic [IDX_W-1:0]     rd_addr;
      logic                 wr_en;
      logic [IDX_W-1:0]     wr_addr;
      logic [WORD_BITS-1:0] wr_data;
   } store_req_type;

   // index of the lowest set bit; zero for an empty word
   function automatic logic [WORD_W-1:0] lowest_set(input logic [WORD_BITS-1:0] word);
      logic [WORD_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (word[i]) idx = WORD_W'(i);
      end
      return idx;
   endfunction

endpackage

/* rtl/core/bmrsf_if.sv */
`timescale 1ns / 1ps

interface bmrsf_req_if;
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic                         fill_value;
   logic [bmrsf_pkg::CNT_W-1:0]  range_start;
   logic [bmrsf_pkg::CNT_W-1:0]  range_length;

   modport source (output valid, command, fill_value, range_start, range_length,
                   input ready);
   modport sink   (input valid, command, fill_value, range_start, range_length,
                   output ready);
endinterface

interface bmrsf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [bmrsf_pkg::POS_W-1:0]  bit_position;

   modport source (output valid, found, bit_position, input ready);
   modport sink   (input valid, found, bit_position, output ready);
endinterface

/* rtl/core/bmrsf_store.sv */
`timescale 1ns / 1ps

module bmrsf_store (
   input  logic                            clock,
   input  logic                            reset,
   input  bmrsf_pkg::store_req_type        store_req,
   output logic [bmrsf_pkg::WORD_BITS-1:0] rd_data
);

   logic [bmrsf_pkg::WORD_BITS-1:0]  mem [bmrsf_pkg::WORD_COUNT];
   logic [bmrsf_pkg::WORD_COUNT-1:0] valid_ff;
   logic [bmrsf_pkg::WORD_BITS-1:0]  rd_data_ff;
   logic                             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_data;
      end
      if (store_req.rd_en) begin
         rd_data_ff <= mem[store_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (store_req.wr_en) valid_ff[store_req.wr_addr] <= 1'b1;
         if (store_req.rd_en) rd_valid_ff <= valid_ff[store_req.rd_addr];
      end
   end

   // a word never written since reset reads as all zero
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

/* rtl/core/bmrsf_seq.sv */
`timescale 1ns / 1ps

module bmrsf_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [bmrsf_pkg::CNT_W-1:0]     bits_in_use,
   bmrsf_req_if.sink                       req_chan,
   bmrsf_rsp_if.source                     rsp_chan,
   output bmrsf_pkg::store_req_type        store_req,
   input  logic [bmrsf_pkg::WORD_BITS-1:0] rd_data
);

   localparam int IW = bmrsf_pkg::IDX_W;
   localparam int BW = bmrsf_pkg::WORD_W;
   localparam int CW = bmrsf_pkg::CNT_W;
   localparam int PW = bmrsf_pkg::POS_W;
   localparam int DW = bmrsf_pkg::WORD_BITS;

   bmrsf_pkg::seq_state_type state_ff, state_in;

   logic          cmd_ff, cmd_in;
   logic          val_ff, val_in;
   logic [IW-1:0] first_ff, first_in;
   logic [IW-1:0] last_ff, last_in;
   logic [BW-1:0] head_ff, head_in;
   logic [BW-1:0] tail_ff, tail_in;
   logic [IW-1:0] rd_word_ff, rd_word_in;
   logic          rd_more_ff, rd_more_in;
   logic          pv_ff, pv_in;
   logic [IW-1:0] pw_ff, pw_in;
   logic          found_ff, found_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_found_ff, rsp_found_in;
   logic [PW-1:0] rsp_pos_ff, rsp_pos_in;

   logic [CW-1:0] lim, s, e, e_last;
   logic [CW:0]   sum;
   logic          empty;
   logic [DW-1:0] mask, match, hits;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmrsf_pkg::ST_IDLE;
         rd_more_ff   <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_more_ff   <= rd_more_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      val_ff      <= val_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      rd_word_ff  <= rd_word_in;
      pw_ff       <= pw_in;
      found_ff    <= found_in;
      pos_ff      <= pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff  <= rsp_pos_in;
   end

   // range clamp for the incoming word
   always_comb begin
      lim    = (bits_in_use > bmrsf_pkg::MAP_LIMIT) ? bmrsf_pkg::MAP_LIMIT : bits_in_use;
      sum    = {1'b0, req_chan.range_start} + {1'b0, req_chan.range_length};
      s      = (req_chan.range_start > lim) ? lim : req_chan.range_start;
      e      = (sum > {1'b0, lim}) ? lim : sum[CW-1:0];
      e_last = e - CW'(1);
      empty  = (s >= e);
   end

   // mask the partial head and tail words, then pick matching bits
   always_comb begin
      mask = '1;
      if (pw_ff == first_ff) mask = mask & ({DW{1'b1}} << head_ff);
      if (pw_ff == last_ff)  mask = mask & ({DW{1'b1}} >> (BW'(DW - 1) - tail_ff));
      match = val_ff ? rd_data : ~rd_data;
      hits  = match & mask;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      rd_word_in   = rd_word_ff;
      rd_more_in   = rd_more_ff;
      pv_in        = pv_ff;
      pw_in        = pw_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      store_req    = '0;
      req_chan.ready = 1'b0;

      case (state_ff)
         bmrsf_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            pv_in      = 1'b0;
            rd_more_in = 1'b0;
            if (req_chan.valid) begin
               cmd_in     = req_chan.command;
               val_in     = req_chan.fill_value;
               first_in   = s[PW-1:BW];
               last_in    = e_last[PW-1:BW];
               head_in    = s[BW-1:0];
               tail_in    = e_last[BW-1:0];
               rd_word_in = s[PW-1:BW];
               found_in   = 1'b0;
               pos_in     = '0;
               if (empty) begin
                  state_in = bmrsf_pkg::ST_FLUSH;
               end else begin
                  rd_more_in = 1'b1;
                  state_in   = bmrsf_pkg::ST_SCAN;
               end
            end
         end

         bmrsf_pkg::ST_SCAN: begin
            // issue the next word read while the previous one is handled
            store_req.rd_en   = rd_more_ff;
            store_req.rd_addr = rd_word_ff;
            rd_word_in = rd_word_ff + IW'(1);
            rd_more_in = rd_more_ff && (rd_word_ff != last_ff);
            pv_in      = rd_more_ff;
            pw_in      = rd_word_ff;
            if (pv_ff) begin
               if (cmd_ff == bmrsf_pkg::CMD_WRITE) begin
                  store_req.wr_en   = 1'b1;
                  store_req.wr_addr = pw_ff;
                  store_req.wr_data = val_ff ? (rd_data | mask) : (rd_data & ~mask);
                  if (pw_ff == last_ff) begin
                     state_in   = bmrsf_pkg::ST_FLUSH;
                     rd_more_in = 1'b0;
                     pv_in      = 1'b0;
                  end
               end else if (|hits) begin
                  found_in   = 1'b1;
                  pos_in     = {pw_ff, bmrsf_pkg::lowest_set(hits)};
                  state_in   = bmrsf_pkg::ST_FLUSH;
                  rd_more_in = 1'b0;
                  pv_in      = 1'b0;
               end else if (pw_ff == last_ff) begin
                  state_in   = bmrsf_pkg::ST_FLUSH;
                  rd_more_in = 1'b0;
                  pv_in      = 1'b0;
               end
            end
         end

         bmrsf_pkg::ST_FLUSH: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_pos_in   = pos_ff;
               state_in     = bmrsf_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bmrsf_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.found        = rsp_found_ff;
   assign rsp_chan.bit_position = rsp_pos_ff;

endmodule

/* rtl/core/bitmap_range_set_find.sv */
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// req_chan  in         valid / ready        command, fill_value, range_start, range_length
// rsp_chan  out        valid / ready        found, bit_position
// csr       in         csr_wr_en (no wait)  csr_wr_data = bits_in_use
//
// A command is accepted in the idle state, where the range is clamped; the single
// registered store read port then streams one word a cycle through the mask and
// find unit, and the flush state hands the result over to the output register.
// An empty range goes straight from the idle state to the flush state.
// Reset clears the store at once through per-word valid bits; no clearing pass.
// A waiting result does not block the scan of the next command, only its hand-over.

module bitmap_range_set_find (
   input  logic                          clock,
   input  logic                          reset,
   bmrsf_req_if.sink                     req_chan,
   bmrsf_rsp_if.source                   rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [bmrsf_pkg::CNT_W-1:0]   csr_wr_data
);

   logic [bmrsf_pkg::CNT_W-1:0]     bits_in_use_ff, bits_in_use_in;
   bmrsf_pkg::store_req_type        store_req;
   logic [bmrsf_pkg::WORD_BITS-1:0] rd_data;

   assign bits_in_use_in = csr_wr_en ? csr_wr_data : bits_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_in_use_ff <= bmrsf_pkg::BITS_IN_USE_RESET;
      end else begin
         bits_in_use_ff <= bits_in_use_in;
      end
   end

   bmrsf_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .bits_in_use (bits_in_use_ff),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .store_req   (store_req),
      .rd_data     (rd_data)
   );

   bmrsf_store u_store (
      .clock     (clock),
      .reset     (reset),
      .store_req (store_req),
      .rd_data   (rd_data)
   );

`ifndef NO_ASSERTIONS
   a_no_rw_same_word: assert property (@(posedge clock) disable iff (reset)
      store_req.wr_en && store_req.rd_en |-> store_req.wr_addr != store_req.rd_addr)
      else $error("store read and write hit the same word");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("new word accepted while a command is in progress");

   a_write_only_busy: assert property (@(posedge clock) disable iff (reset)
      store_req.wr_en |-> !req_chan.ready)
      else $error("store written while idle");

   a_miss_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.found |-> rsp_chan.bit_position == '0)
      else $error("position not zero on a miss");
`endif

endmodule

/* tb/sv/tb_bitmap_range_set_find.sv */
`timescale 1ns / 1ps

module tb_bitmap_range_set_find;

   localparam int MAP_BITS     = bmrsf_pkg::MAP_BITS;
   localparam int WORD_BITS    = bmrsf_pkg::WORD_BITS;
   localparam int POS_W        = bmrsf_pkg::POS_W;
   localparam int CNT_W        = bmrsf_pkg::CNT_W;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int TAIL_CYCLES  = bmrsf_pkg::WORD_COUNT + 16;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] bit_position;
   } find_word_type;

   logic clock;
   logic reset;
   logic             csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;

   bmrsf_req_if req_if ();
   bmrsf_rsp_if rsp_if ();

   bitmap_range_set_find dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow copy of the bit store and of bits_in_use
   logic [MAP_BITS-1:0] map_image;
   logic [CNT_W-1:0]    limit_shadow;
   find_word_type       pending_finds[$];

   int unsigned gap_max;
   int unsigned stall_max;
   int unsigned rsp_wait       = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // apply one command to the shadow store and return the word it should produce
   function automatic find_word_type apply_command(bmrsf_pkg::cmd_type cmd, logic val,
                                                   int unsigned rs, int unsigned rl);
      int unsigned   lim;
      int unsigned   first;
      int unsigned   stop;
      find_word_type res;
      lim   = (limit_shadow > MAP_BITS) ? MAP_BITS : limit_shadow;
      first = (rs < lim) ? rs : lim;
      stop  = (rs + rl < lim) ? rs + rl : lim;
      res   = '0;
      if (cmd == bmrsf_pkg::CMD_WRITE) begin
         for (int unsigned i = first; i < stop; i++) map_image[i] = val;
      end else begin
         for (int unsigned i = first; i < stop && !res.found; i++) begin
            if (map_image[i] == val) begin
               res.found        = 1'b1;
               res.bit_position = POS_W'(i);
            end
         end
      end
      return res;
   endfunction

   // result side: random stalls and in-order compare
   always @(posedge clock) begin
      find_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_finds.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result word: found=%0d bit_position=%0d",
                        rsp_if.found, rsp_if.bit_position);
         end else begin
            want = pending_finds.pop_front();
            if (rsp_if.found !== want.found ||
                rsp_if.bit_position !== want.bit_position) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("mismatch: expected found=%0d bit_position=%0d, %s%0d %s%0d",
                           want.found, want.bit_position,
                           "got found=", rsp_if.found,
                           "bit_position=", rsp_if.bit_position);
            end
         end
         rsp_wait = $urandom_range(0, stall_max);
      end
      if (rsp_wait > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_wait--;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // leaves valid high after the handshake so a zero gap keeps it asserted
   task automatic send_command(bmrsf_pkg::cmd_type cmd, logic val,
                               int unsigned rs, int unsigned rl);
      int unsigned gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.command      <= cmd;
      req_if.fill_value   <= val;
      req_if.range_start  <= CNT_W'(rs);
      req_if.range_length <= CNT_W'(rl);
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_finds.push_back(apply_command(cmd, val, rs, rl));
   endtask

   task automatic hold_requests();
      req_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_for_results();
      hold_requests();
      while (pending_finds.size() != 0) @(posedge clock);
   endtask

   task automatic set_bits_in_use(int unsigned value);
      wait_for_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CNT_W'(value);
      @(posedge clock);
      limit_shadow = CNT_W'(value);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic check_cleared_map();
      send_command(bmrsf_pkg::CMD_FIND, 1'b1, 0, MAP_BITS);
      send_command(bmrsf_pkg::CMD_FIND, 1'b0, 0, MAP_BITS);
      send_command(bmrsf_pkg::CMD_WRITE, 1'b1, 0, MAP_BITS);
      send_command(bmrsf_pkg::CMD_FIND, 1'b0, 0, MAP_BITS);
   endtask

   task automatic check_word_edges();
      // clear the two bits either side of the first word boundary
      send_command(bmrsf_pkg::CMD_WRITE, 1'b0, WORD_BITS - 1, 2);
      send_command(bmrsf_pkg::CMD_FIND, 1'b0, 0, MAP_BITS);
      send_command(bmrsf_pkg::CMD_FIND, 1'b0, WORD_BITS, 100);
      send_command(bmrsf_pkg::CMD_WRITE, 1'b0, 100, 0);
      send_command(bmrsf_pkg::CMD_FIND, 1'b0, 33, 4000);
      send_command(bmrsf_pkg::CMD_FIND, 1'b1, MAP_BITS - 1, 1);
   endtask

   task automatic check_range_clamp();
      send_command(bmrsf_pkg::CMD_FIND, 1'b1, 8191, 8191);
      send_command(bmrsf_pkg::CMD_WRITE, 1'b0, MAP_BITS, 1);
      send_command(bmrsf_pkg::CMD_WRITE, 1'b0, 4000, 8191);
      send_command(bmrsf_pkg::CMD_FIND, 1'b0, 3990, 8191);
      set_bits_in_use(0);
      send_command(bmrsf_pkg::CMD_FIND, 1'b0, 0, MAP_BITS);
      send_command(bmrsf_pkg::CMD_WRITE, 1'b0, 0, MAP_BITS);
      set_bits_in_use(33);
      send_command(bmrsf_pkg::CMD_WRITE, 1'b0, 0, 8191);
      send_command(bmrsf_pkg::CMD_FIND, 1'b1, 0, MAP_BITS);
      send_command(bmrsf_pkg::CMD_FIND, 1'b0, 32, 5);
      send_command(bmrsf_pkg::CMD_FIND, 1'b0, 33, 1);
      set_bits_in_use(1);
      send_command(bmrsf_pkg::CMD_FIND, 1'b0, 0, 1);
   endtask

   task automatic check_oversized_limit();
      set_bits_in_use(8191);
      send_command(bmrsf_pkg::CMD_WRITE, 1'b1, 4080, 100);
      send_command(bmrsf_pkg::CMD_FIND, 1'b1, 4070, 8191);
      send_command(bmrsf_pkg::CMD_FIND, 1'b0, 4080, 8191);
   endtask

   task automatic check_random_traffic(int unsigned limit, int unsigned count,
                                       int unsigned gaps, int unsigned stalls);
      int unsigned        lim;
      int unsigned        rs;
      int unsigned        rl;
      int unsigned        pick;
      bmrsf_pkg::cmd_type cmd;
      set_bits_in_use(limit);
      gap_max   = gaps;
      stall_max = stalls;
      lim = (limit > MAP_BITS) ? MAP_BITS : limit;
      for (int n = 0; n < count; n++) begin
         cmd  = ($urandom_range(0, 9) < 4) ? bmrsf_pkg::CMD_WRITE : bmrsf_pkg::CMD_FIND;
         pick = $urandom_range(0, 9);
         if (pick == 0)
            rs = $urandom_range(0, 8191);
         else if (pick == 1)
            rs = (lim > 40) ? lim - $urandom_range(0, 40) : $urandom_range(0, lim);
         else
            rs = $urandom_range(0, (lim > 0) ? lim - 1 : 0);
         pick = $urandom_range(0, 9);
         if (pick == 0)
            rl = $urandom_range(0, 8191);
         else if (pick == 1)
            rl = 0;
         else if (pick == 2)
            rl = $urandom_range(0, MAP_BITS);
         else
            rl = $urandom_range(1, 96);
         send_command(cmd, 1'($urandom_range(0, 1)), rs, rl);
         // drain now and then so the block sees an empty pipe
         if ($urandom_range(0, 63) == 0) wait_for_results();
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_if.valid        = 1'b0;
      req_if.command      = bmrsf_pkg::CMD_WRITE;
      req_if.fill_value   = 1'b0;
      req_if.range_start  = '0;
      req_if.range_length = '0;
      map_image           = '0;
      limit_shadow        = bmrsf_pkg::BITS_IN_USE_RESET;
      gap_max             = 4;
      stall_max           = 4;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      check_cleared_map();
      check_word_edges();
      check_range_clamp();
      check_oversized_limit();

      check_random_traffic(MAP_BITS, 250, 4, 4);
      check_random_traffic($urandom_range(1, MAP_BITS - 1), 150, 4, 4);
      check_random_traffic(MAP_BITS, 150, 0, 0);
      check_random_traffic(8191, 150, 4, 0);
      check_random_traffic(MAP_BITS - 1, 150, 0, 4);
      check_random_traffic($urandom_range(MAP_BITS + 1, 8190), 100, 4, 4);
      check_random_traffic(37, 100, 4, 4);
      check_random_traffic(0, 30, 4, 4);
      check_random_traffic(MAP_BITS, 120, 4, 4);

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_finds.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
